[rtl/core/lrucb_pkg.sv]
// lrucb_pkg: shared constants, codes and types of the texture slot cache.
// No dependencies; imported by every module of the block except lrucb_ram.
package lrucb_pkg;
   localparam int NUM_SLOTS_DEF = 128;
   localparam int TAG_BITS_DEF  = 64;
   localparam int AGE_BITS      = 32;
   localparam int SIZE_BITS     = 18;
   localparam int BYTES_BITS    = 23;
   localparam int KEY_BITS      = 64;
   localparam logic [BYTES_BITS-1:0] BUDGET_RESET = 23'd2097152;

   localparam logic [1:0] OUTCOME_HIT    = 2'd0;
   localparam logic [1:0] OUTCOME_MISS   = 2'd1;
   localparam logic [1:0] OUTCOME_NOROOM = 2'd2;

   typedef struct packed {
      logic [7:0] evicted_count;
      logic       flush_request;
      logic [6:0] slot_index;
      logic [1:0] outcome;
   } lrucb_result_type;
endpackage

[rtl/core/lrucb_ram.sv]
// lrucb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module lrucb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/core/lrucb_engine.sv]
// lrucb_engine: slot table sequencer - lookup scan, victim choice, oldest-entry
// eviction scans and install. Depends on lrucb_pkg and lrucb_ram.
module lrucb_engine #(
   parameter int NUM_SLOTS = 128,
   parameter int TAG_BITS  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [TAG_BITS-1:0]               key_tag,
   input  logic [lrucb_pkg::SIZE_BITS-1:0]   entry_bytes,
   input  logic [lrucb_pkg::BYTES_BITS-1:0]  byte_budget,
   output logic                              idle,
   output logic                              res_valid,
   output lrucb_pkg::lrucb_result_type       res,
   input  logic                              res_take
);
   import lrucb_pkg::*;

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = IW + 1;
   localparam int RW = TAG_BITS + AGE_BITS + SIZE_BITS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_EVSCAN = 3'd4;
   localparam logic [2:0] S_EVICT  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  p_vld_ff, p_vld_in;
   logic [IW-1:0]         p_idx_ff, p_idx_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [SIZE_BITS-1:0]  need_ff, need_in;
   logic                  hit_ff, hit_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic [SIZE_BITS-1:0]  hit_size_ff, hit_size_in;
   logic                  empty_ff, empty_in;
   logic [IW-1:0]         vic_ff, vic_in;
   logic [AGE_BITS-1:0]   vic_age_ff, vic_age_in;
   logic [SIZE_BITS-1:0]  vic_size_ff, vic_size_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         old_idx_ff, old_idx_in;
   logic [AGE_BITS-1:0]   old_age_ff, old_age_in;
   logic [SIZE_BITS-1:0]  old_size_ff, old_size_in;
   logic [BYTES_BITS-1:0] bytes_ff, bytes_in;
   logic [AGE_BITS-1:0]   age_clk_ff, age_clk_in;
   logic [CW-1:0]         evicted_ff, evicted_in;
   logic                  flush_ff, flush_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;
   lrucb_result_type      res_ff, res_in;

   logic                  ram_we;
   logic [IW-1:0]         ram_waddr;
   logic [RW-1:0]         ram_wdata;
   logic [RW-1:0]         ram_rdata;
   logic [TAG_BITS-1:0]   r_tag;
   logic [AGE_BITS-1:0]   r_age;
   logic [SIZE_BITS-1:0]  r_size;
   logic                  r_valid;
   logic [BYTES_BITS:0]   sum;
   logic                  over;
   logic                  last;

   lrucb_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cnt_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign r_tag   = ram_rdata[RW-1 -: TAG_BITS];
   assign r_age   = ram_rdata[SIZE_BITS +: AGE_BITS];
   assign r_size  = ram_rdata[SIZE_BITS-1:0];
   assign r_valid = valid_ff[p_idx_ff];
   assign sum     = {1'b0, bytes_ff} + {{(BYTES_BITS+1-SIZE_BITS){1'b0}}, need_ff};
   assign over    = sum > {1'b0, byte_budget};
   assign last    = p_vld_ff && (p_idx_ff == IW'(NUM_SLOTS - 1));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      p_vld_in    = 1'b0;
      p_idx_in    = cnt_ff[IW-1:0];
      tag_in      = tag_ff;
      need_in     = need_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_size_in = hit_size_ff;
      empty_in    = empty_ff;
      vic_in      = vic_ff;
      vic_age_in  = vic_age_ff;
      vic_size_in = vic_size_ff;
      found_in    = found_ff;
      old_idx_in  = old_idx_ff;
      old_age_in  = old_age_ff;
      old_size_in = old_size_ff;
      bytes_in    = bytes_ff;
      age_clk_in  = age_clk_ff;
      evicted_in  = evicted_ff;
      flush_in    = flush_ff;
      valid_in    = valid_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = vic_ff;
      ram_wdata   = {tag_ff, age_clk_ff + AGE_BITS'(1), need_ff};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               tag_in     = key_tag;
               need_in    = entry_bytes;
               cnt_in     = '0;
               hit_in     = 1'b0;
               empty_in   = 1'b0;
               vic_in     = '0;
               evicted_in = '0;
               flush_in   = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN, S_EVSCAN: begin
            if (cnt_ff < CW'(NUM_SLOTS)) begin
               p_vld_in = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
            end
            if (p_vld_ff) begin
               if (state_ff == S_SCAN) begin
                  if (r_valid && r_tag == tag_ff && !hit_ff) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = p_idx_ff;
                     hit_size_in = r_size;
                  end
                  if (!r_valid) begin
                     vic_in   = p_idx_ff;
                     empty_in = 1'b1;
                  end else if (p_idx_ff == '0) begin
                     vic_age_in  = r_age;
                     vic_size_in = r_size;
                  end else if (!empty_ff && r_age < vic_age_ff) begin
                     vic_in      = p_idx_ff;
                     vic_age_in  = r_age;
                     vic_size_in = r_size;
                  end
               end else if (r_valid && (!found_ff || r_age < old_age_ff)) begin
                  found_in    = 1'b1;
                  old_idx_in  = p_idx_ff;
                  old_age_in  = r_age;
                  old_size_in = r_size;
               end
            end
            if (last) begin
               state_in = (state_ff == S_SCAN) ? S_DECIDE : S_EVICT;
            end
         end
         S_DECIDE: begin
            if (hit_ff) begin
               ram_we     = 1'b1;
               ram_waddr  = hit_idx_ff;
               ram_wdata  = {tag_ff, age_clk_ff + AGE_BITS'(1), hit_size_ff};
               age_clk_in = age_clk_ff + AGE_BITS'(1);
               res_in     = '{evicted_count: 8'd0, flush_request: 1'b0,
                              slot_index: 7'(hit_idx_ff), outcome: OUTCOME_HIT};
               state_in   = S_DONE;
            end else begin
               flush_in = !empty_ff || over;
               if (!empty_ff) begin
                  valid_in[vic_ff] = 1'b0;
                  bytes_in   = bytes_ff - BYTES_BITS'(vic_size_ff);
                  evicted_in = CW'(1);
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (over) begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_EVSCAN;
            end else begin
               ram_we           = 1'b1;
               valid_in[vic_ff] = 1'b1;
               bytes_in   = sum[BYTES_BITS-1:0];
               age_clk_in = age_clk_ff + AGE_BITS'(1);
               res_in     = '{evicted_count: 8'(evicted_ff), flush_request: flush_ff,
                              slot_index: 7'(vic_ff), outcome: OUTCOME_MISS};
               state_in   = S_DONE;
            end
         end
         S_EVICT: begin
            if (!found_ff) begin
               res_in   = '{evicted_count: 8'(evicted_ff), flush_request: 1'b1,
                            slot_index: 7'd0, outcome: OUTCOME_NOROOM};
               state_in = S_DONE;
            end else begin
               valid_in[old_idx_ff] = 1'b0;
               bytes_in   = bytes_ff - BYTES_BITS'(old_size_ff);
               evicted_in = evicted_ff + CW'(1);
               state_in   = S_CHECK;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         p_vld_ff   <= 1'b0;
         valid_ff   <= '0;
         bytes_ff   <= '0;
         age_clk_ff <= '0;
      end else begin
         state_ff   <= state_in;
         p_vld_ff   <= p_vld_in;
         valid_ff   <= valid_in;
         bytes_ff   <= bytes_in;
         age_clk_ff <= age_clk_in;
      end
      cnt_ff      <= cnt_in;
      p_idx_ff    <= p_idx_in;
      tag_ff      <= tag_in;
      need_ff     <= need_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_size_ff <= hit_size_in;
      empty_ff    <= empty_in;
      vic_ff      <= vic_in;
      vic_age_ff  <= vic_age_in;
      vic_size_ff <= vic_size_in;
      found_ff    <= found_in;
      old_idx_ff  <= old_idx_in;
      old_age_ff  <= old_age_in;
      old_size_ff <= old_size_in;
      evicted_ff  <= evicted_in;
      flush_ff    <= flush_in;
      res_ff      <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;
endmodule

[rtl/core/lru_texture_slot_cache_with_budget.sv]
// Timing: a hit or a miss takes one scan of the slot RAM, one read per cycle; each extra
// oldest-entry eviction adds another full scan of the slot RAM.
// Throughput: one transaction at a time; the next is taken while a result waits.
// Reset: synchronous; clears valid bits, byte total, age clock, budget to 2 MiB.
// Depends on lrucb_pkg, lrucb_engine, lrucb_ram.
module lru_texture_slot_cache_with_budget #(
   parameter int NUM_SLOTS = lrucb_pkg::NUM_SLOTS_DEF,
   parameter int TAG_BITS  = lrucb_pkg::TAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // key_tag[63:0], entry_bytes[81:64], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // outcome[1:0], slot_index[8:2], flush_request[9],
                                    // evicted_count[17:10], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lrucb_pkg::*;

   logic [BYTES_BITS-1:0] budget_ff;
   logic                  out_vld_ff;
   lrucb_result_type      out_ff;
   logic                  eng_idle;
   logic                  res_valid;
   lrucb_result_type      res;
   logic                  res_take;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-BYTES_BITS){1'b0}}, budget_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         budget_ff <= csr_pwdata[BYTES_BITS-1:0];
      end
   end

   assign req_tready = eng_idle;
   assign res_take   = res_valid && (!out_vld_ff || rsp_tready);

   lrucb_engine #(.NUM_SLOTS(NUM_SLOTS), .TAG_BITS(TAG_BITS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && eng_idle),
      .key_tag     (req_tdata[TAG_BITS-1:0]),
      .entry_bytes (req_tdata[KEY_BITS +: SIZE_BITS]),
      .byte_budget (budget_ff),
      .idle        (eng_idle),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (res_take) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
      if (res_take) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, out_ff};
endmodule

[rtl/core/lrucb_checker.sv]
// lrucb_checker: port-level assertions for the texture slot cache, bound to
// the top level. Depends on lrucb_pkg.
module lrucb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import lrucb_pkg::*;

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == OUTCOME_HIT || rsp_tdata[1:0] == OUTCOME_MISS ||
                      rsp_tdata[1:0] == OUTCOME_NOROOM))
      else $error("bad outcome code");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == OUTCOME_HIT) |-> (rsp_tdata[17:9] == 9'd0))
      else $error("hit with flush or evictions");

   a_noroom: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == OUTCOME_NOROOM) |->
      (rsp_tdata[8:2] == 7'd0 && rsp_tdata[9]))
      else $error("no room result malformed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken while busy");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
endmodule

bind lru_texture_slot_cache_with_budget lrucb_checker u_lrucb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/lrucb_checker.sv]
// lrucb_scoreboard: watches the request, response and register channels of the slot cache,
// predicts each response and compares it field by field.
// Depends on lrucb_pkg.
module lrucb_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,   // key_tag[63:0], entry_bytes[81:64], zero pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // outcome[1:0], slot_index[8:2], flush_request[9],
                                    // evicted_count[17:10], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending,
   output int          hits,
   output int          misses,
   output int          norooms
);
   timeunit 1ns;
   timeprecision 1ps;
   import lrucb_pkg::*;

   localparam int SLOTS = NUM_SLOTS_DEF;

   logic                  slot_live [SLOTS];
   logic [KEY_BITS-1:0]   slot_key  [SLOTS];
   logic [AGE_BITS-1:0]   slot_stamp[SLOTS];
   logic [SIZE_BITS-1:0]  slot_bytes[SLOTS];
   logic [AGE_BITS-1:0]   stamp_now;
   logic [BYTES_BITS-1:0] bytes_used;
   logic [BYTES_BITS-1:0] budget;
   lrucb_result_type      outcome_q[$];

   function automatic lrucb_result_type lookup_and_install(logic [63:0] key,
                                                           logic [17:0] need);
      lrucb_result_type r;
      int victim;
      int oldest;
      bit empty_seen;
      r = '0;
      victim = 0;
      empty_seen = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && slot_key[i] == key) begin
            stamp_now++;
            slot_stamp[i] = stamp_now;
            r.outcome = OUTCOME_HIT;
            r.slot_index = i[6:0];
            return r;
         end
         if (!slot_live[i]) begin
            victim = i;
            empty_seen = 1;
         end else if (!empty_seen && slot_stamp[i] < slot_stamp[victim]) begin
            victim = i;
         end
      end
      if (slot_live[victim] || 32'(bytes_used) + 32'(need) > 32'(budget)) begin
         r.flush_request = 1;
         if (slot_live[victim]) begin
            bytes_used = bytes_used - 23'(slot_bytes[victim]);
            slot_live[victim] = 0;
            r.evicted_count++;
         end
         while (32'(bytes_used) + 32'(need) > 32'(budget)) begin
            oldest = SLOTS;
            for (int i = 0; i < SLOTS; i++)
               if (slot_live[i] && (oldest == SLOTS || slot_stamp[i] < slot_stamp[oldest]))
                  oldest = i;
            if (oldest == SLOTS) begin
               r.outcome = OUTCOME_NOROOM;
               r.slot_index = '0;
               return r;
            end
            bytes_used = bytes_used - 23'(slot_bytes[oldest]);
            slot_live[oldest] = 0;
            r.evicted_count++;
         end
      end
      stamp_now++;
      slot_live[victim] = 1;
      slot_key[victim] = key;
      slot_stamp[victim] = stamp_now;
      slot_bytes[victim] = need;
      bytes_used = bytes_used + 23'(need);
      r.outcome = OUTCOME_MISS;
      r.slot_index = victim[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      lrucb_result_type got;
      lrucb_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_live[i] = 0;
         stamp_now = '0;
         bytes_used = '0;
         budget = BUDGET_RESET;
         outcome_q.delete();
         errors = 0;
         hits = 0;
         misses = 0;
         norooms = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2])
            budget = csr_pwdata[BYTES_BITS-1:0];
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[17:0];
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, actual %h", $time, got);
            end else begin
               want = outcome_q.pop_front();
               if (got.outcome !== want.outcome || got.slot_index !== want.slot_index ||
                   got.flush_request !== want.flush_request ||
                   got.evicted_count !== want.evicted_count) begin
                  errors++;
                  $display("%0t: mismatch expected outcome %0d slot %0d flush %0d evicted %0d",
                           $time, want.outcome, want.slot_index, want.flush_request,
                           want.evicted_count);
                  $display("%0t:          actual   outcome %0d slot %0d flush %0d evicted %0d",
                           $time, got.outcome, got.slot_index, got.flush_request,
                           got.evicted_count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = lookup_and_install(req_tdata[63:0], req_tdata[81:64]);
            case (want.outcome)
               OUTCOME_HIT:  hits++;
               OUTCOME_MISS: misses++;
               default:      norooms++;
            endcase
            outcome_q.push_back(want);
         end
      end
      pending = outcome_q.size();
   end
endmodule

[bench/testbench.sv]
// testbench: drives requests, register writes and response back-pressure into the
// texture slot cache; checking is done by lrucb_scoreboard and the bound lrucb_checker.
// Depends on lrucb_pkg, lrucb_scoreboard and the block itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lrucb_pkg::*;

   localparam int STALL_LIMIT = 100000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // key_tag[63:0], entry_bytes[81:64], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;        // outcome[1:0], slot_index[8:2], flush_request[9],
                                  // evicted_count[17:10], zero pad
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors, pending, hits, misses, norooms;
   int sent = 0;
   int idle_cycles = 0;
   logic [63:0] key_pool[200];

   always #4 clock = ~clock;

   lru_texture_slot_cache_with_budget dut (.*);

   lrucb_scoreboard u_scoreboard (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .errors, .pending, .hits, .misses, .norooms
   );

   function automatic bit quiet_stretch();
      return sent >= 500 && sent < 650;
   endfunction

   // receiver: random stalls, one long hold-off
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (sent == 800 && hold == 0) hold = 400;
         if (hold > 1) begin
            hold--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= quiet_stretch() || $urandom_range(99) >= 9;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d responses pending", pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic [63:0] key, input logic [17:0] need);
      while (!quiet_stretch() && $urandom_range(99) < 9) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, need, key};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic random_requests(input int count, input int max_bytes);
      logic [63:0] key;
      logic [17:0] need;
      int pick;
      repeat (count) begin
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(199)]
                                         : {$urandom, $urandom};
         pick = $urandom_range(99);
         if (pick < 60)      need = 18'($urandom_range(2048, 128));
         else if (pick < 95) need = 18'($urandom_range(max_bytes, 128));
         else                need = 18'($urandom);
         send_request(key, need);
      end
   endtask

   initial begin
      for (int i = 0; i < 200; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: extremes, hits, special sizes
      send_request(64'h0, 18'd128);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 18'd131072);
      send_request(64'h0, 18'd128);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 18'd200);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 18'd0);
      send_request(64'h5555_5555_5555_5555, 18'h3FFFF);
      send_request(64'h0123_4567_89AB_CDEF, 18'h15555);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 18'h2AAAA);
      drain();
      write_csr(3'd0, 32'd1000);            // below bytes in use: next miss evicts
      send_request(64'h77, 18'd500);
      send_request(64'h78, 18'd2000);       // larger than budget: no room
      send_request(64'h77, 18'd500);
      drain();
      write_csr(3'd0, 32'd0);
      send_request(64'h79, 18'd0);
      send_request(64'h7A, 18'd128);
      send_request(64'h79, 18'd0);
      drain();

      write_csr(3'd0, 32'h7F_FFFF);
      random_requests(220, 131072);         // fills all slots, slot eviction
      drain();
      write_csr(3'd0, 32'd200000);
      random_requests(150, 30000);
      drain();
      write_csr(3'd0, 32'd4194304);
      random_requests(120, 131072);
      drain();
      write_csr(3'd4, 32'hFFFF_FFFF);       // no such register
      write_csr(3'd0, 32'(BUDGET_RESET));
      random_requests(445, 131072);
      drain();

      $display("%0d requests: %0d hits, %0d misses, %0d no room, six budget values",
               sent, hits, misses, norooms);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
